// File: design/cbtt_pkg.sv
// Shared codes, field widths and bus layout for the bus transaction tracker.
package cbtt_pkg;

    // input kinds, carried on s_axis_tuser
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_WRITE = 3'd2;
    localparam logic [2:0] KIND_RESP  = 3'd3;
    localparam logic [2:0] KIND_DATA  = 3'd4;

    // response codes
    localparam logic [1:0] RESP_DATA_CMPL = 2'd0;
    localparam logic [1:0] RESP_BUF_ID    = 2'd1;

    // outcomes, carried on m_axis_tuser
    localparam logic [1:0] OUT_ACCEPTED = 2'd0;
    localparam logic [1:0] OUT_REJECTED = 2'd1;
    localparam logic [1:0] OUT_COMPLETED = 2'd2;
    localparam logic [1:0] OUT_FAILED   = 2'd3;

    localparam int KIND_W = 3;
    localparam int OUTC_W = 2;
    localparam int CFG_W  = 5;
    localparam logic [CFG_W-1:0] MAX_OUT_RESET = 5'd16;

    // input tdata layout
    localparam int IN_DATA_W = 192;
    localparam int IN_TAG_LSB  = 0;
    localparam int IN_ADDR_LSB = 32;
    localparam int IN_SIZE_LSB = 96;
    localparam int IN_MID_LSB  = 104;
    localparam int IN_CODE_LSB = 120;
    localparam int IN_WORD_LSB = 122;

    // output tdata layout
    localparam int OUT_DATA_W = 320;

    typedef struct packed {
        logic [63:0] finished_at;
        logic [63:0] issued_at;
        logic [63:0] payload_word;
        logic        has_payload;
        logic        is_write;
        logic [7:0]  txn_size;
        logic [63:0] txn_address;
        logic [31:0] owner_tag;
        logic [15:0] txn_tag;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// File: design/coherent_bus_txn_tracker_unit.sv
// Top level: outstanding bus transaction tracker with parallel ID match.
//
//  channel   direction  transfer when                    carries
//  s_axis    in         s_axis_tvalid & s_axis_tready    one event (tick/req/resp/data)
//  m_axis    out        m_axis_tvalid & m_axis_tready    one result (accept/reject/done/fail)
//  cfg       in         i_cfg_valid & o_cfg_ready        outstanding limit
//
// One event per cycle while the result register can take it: the table lookup, free-slot
// search and valid count all resolve combinationally from the slot registers into the result register.
// An event is taken whenever the result register is empty or being drained.
// Synchronous active-low reset clears the slot valid bits, ID and cycle counters,
// and sets the outstanding limit to 16. Slot payload registers are not reset.
module coherent_bus_txn_tracker_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: instruction_tag, address, access_size, match_id, response_code, data_word
    input  logic [cbtt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: kind
    input  logic [cbtt_pkg::KIND_W-1:0]     s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: txn_tag, owner_tag, txn_address, txn_size, is_write, has_payload,
    //        payload_word, issued_at, finished_at
    output logic [cbtt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: outcome
    output logic [cbtt_pkg::OUTC_W-1:0]     m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [cbtt_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W = (CNT_W > cbtt_pkg::CFG_W) ? CNT_W : cbtt_pkg::CFG_W;
    localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;

    // slot storage
    logic [TABLE_DEPTH-1:0] r_slot_valid;
    logic [ID_BITS-1:0]     r_slot_id      [TABLE_DEPTH];
    logic [31:0]            r_slot_owner   [TABLE_DEPTH];
    logic [63:0]            r_slot_address [TABLE_DEPTH];
    logic [7:0]             r_slot_size    [TABLE_DEPTH];
    logic                   r_slot_write   [TABLE_DEPTH];
    logic [63:0]            r_slot_issue   [TABLE_DEPTH];

    logic [ID_BITS-1:0]     r_next_id;
    logic [63:0]            r_cycle;
    logic [cbtt_pkg::CFG_W-1:0] r_max_out;

    logic                   r_o_valid;
    logic [cbtt_pkg::OUTC_W-1:0] r_o_user;
    cbtt_pkg::t_result      r_o_res;

    // input fields
    logic [2:0]  w_kind;
    logic [31:0] w_tag;
    logic [63:0] w_addr;
    logic [7:0]  w_size;
    logic [15:0] w_mid;
    logic [1:0]  w_code;
    logic [63:0] w_word;

    assign w_kind = s_axis_tuser;
    assign w_tag  = s_axis_tdata[cbtt_pkg::IN_TAG_LSB  +: 32];
    assign w_addr = s_axis_tdata[cbtt_pkg::IN_ADDR_LSB +: 64];
    assign w_size = s_axis_tdata[cbtt_pkg::IN_SIZE_LSB +: 8];
    assign w_mid  = s_axis_tdata[cbtt_pkg::IN_MID_LSB  +: 16];
    assign w_code = s_axis_tdata[cbtt_pkg::IN_CODE_LSB +: 2];
    assign w_word = s_axis_tdata[cbtt_pkg::IN_WORD_LSB +: 64];

    logic w_in_acc;
    assign s_axis_tready = !r_o_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // per-slot match, lowest-index-first select, free search, occupancy
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_sel;
    logic [TABLE_DEPTH-1:0] w_taken;
    logic                   w_any_hit;
    logic [IDX_W-1:0]       w_free_idx;
    logic                   w_any_free;
    logic [CNT_W-1:0]       w_count;

    always_comb begin
        w_hit      = '0;
        w_sel      = '0;
        w_taken    = '0;
        w_free_idx = '0;
        w_any_free = 1'b0;
        w_count    = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_hit[i] = r_slot_valid[i] &&
                       (CMP_W'(r_slot_id[i]) == CMP_W'(w_mid));
            w_count  = w_count + CNT_W'(r_slot_valid[i]);
        end
        // one-hot of the lowest hit
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) begin
                w_taken[i] = w_hit[i];
                w_sel[i]   = w_hit[i];
            end else begin
                w_taken[i] = w_taken[i-1] || w_hit[i];
                w_sel[i]   = w_hit[i] && !w_taken[i-1];
            end
        end
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_slot_valid[i]) begin
                w_free_idx = IDX_W'(i);
                w_any_free = 1'b1;
            end
        end
    end

    assign w_any_hit = |w_hit;

    // AND-OR read of the selected slot
    logic [ID_BITS-1:0] w_m_id;
    logic [31:0]        w_m_owner;
    logic [63:0]        w_m_addr;
    logic [7:0]         w_m_size;
    logic               w_m_write;
    logic [63:0]        w_m_issue;

    always_comb begin
        w_m_id    = '0;
        w_m_owner = '0;
        w_m_addr  = '0;
        w_m_size  = '0;
        w_m_write = 1'b0;
        w_m_issue = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_sel[i]) begin
                w_m_id    = w_m_id    | r_slot_id[i];
                w_m_owner = w_m_owner | r_slot_owner[i];
                w_m_addr  = w_m_addr  | r_slot_address[i];
                w_m_size  = w_m_size  | r_slot_size[i];
                w_m_write = w_m_write | r_slot_write[i];
                w_m_issue = w_m_issue | r_slot_issue[i];
            end
        end
    end

    // event decode
    logic                 w_is_req;
    logic                 w_req_wr;
    logic                 w_req_ok;
    logic                 w_res_valid;
    logic                 w_release;
    logic [cbtt_pkg::OUTC_W-1:0] w_outc;
    cbtt_pkg::t_result    w_res;
    logic [1:0]           w_expect;

    always_comb begin
        w_is_req    = 1'b0;
        w_req_wr    = 1'b0;
        w_req_ok    = 1'b0;
        w_res_valid = 1'b0;
        w_release   = 1'b0;
        w_outc      = cbtt_pkg::OUT_ACCEPTED;
        w_res       = '0;
        w_expect    = w_m_write ? cbtt_pkg::RESP_BUF_ID : cbtt_pkg::RESP_DATA_CMPL;

        case (w_kind)
            cbtt_pkg::KIND_READ, cbtt_pkg::KIND_WRITE: begin
                w_is_req    = 1'b1;
                w_req_wr    = (w_kind == cbtt_pkg::KIND_WRITE);
                w_req_ok    = w_any_free &&
                              (LIM_W'(w_count) < LIM_W'(r_max_out));
                w_res_valid = 1'b1;
                w_res.owner_tag   = w_tag;
                w_res.txn_address = w_addr;
                w_res.txn_size    = w_size;
                w_res.is_write    = w_req_wr;
                if (w_req_ok) begin
                    w_outc          = cbtt_pkg::OUT_ACCEPTED;
                    w_res.txn_tag   = 16'(CMP_W'(r_next_id));
                    w_res.issued_at = r_cycle;
                end else begin
                    w_outc = cbtt_pkg::OUT_REJECTED;
                end
            end
            cbtt_pkg::KIND_RESP, cbtt_pkg::KIND_DATA: begin
                w_res.txn_tag     = 16'(CMP_W'(w_m_id));
                w_res.owner_tag   = w_m_owner;
                w_res.txn_address = w_m_addr;
                w_res.txn_size    = w_m_size;
                w_res.is_write    = w_m_write;
                w_res.issued_at   = w_m_issue;
                if (w_kind == cbtt_pkg::KIND_DATA) begin
                    w_release          = w_any_hit;
                    w_res_valid        = w_any_hit;
                    w_outc             = cbtt_pkg::OUT_COMPLETED;
                    w_res.has_payload  = 1'b1;
                    w_res.payload_word = w_word;
                    w_res.finished_at  = r_cycle;
                end else if (w_code == w_expect) begin
                    // data completion on a read only parks the entry
                    if (w_code != cbtt_pkg::RESP_DATA_CMPL) begin
                        w_release         = w_any_hit;
                        w_res_valid       = w_any_hit;
                        w_outc            = cbtt_pkg::OUT_COMPLETED;
                        w_res.finished_at = r_cycle;
                    end
                end else begin
                    w_release   = w_any_hit;
                    w_res_valid = w_any_hit;
                    w_outc      = cbtt_pkg::OUT_FAILED;
                end
            end
            default: begin
            end
        endcase
    end

    logic w_alloc;
    assign w_alloc = w_in_acc && w_is_req && w_req_ok;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_next_id    <= '0;
            r_cycle      <= '0;
            r_max_out    <= cbtt_pkg::MAX_OUT_RESET;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_out <= i_cfg_data;
            end
            if (w_in_acc && (w_kind == cbtt_pkg::KIND_TICK)) begin
                r_cycle <= r_cycle + 64'd1;
            end
            if (w_alloc) begin
                r_slot_valid[w_free_idx] <= 1'b1;
                r_next_id <= r_next_id + ID_BITS'(1);
            end
            if (w_in_acc && w_release) begin
                r_slot_valid <= r_slot_valid & ~w_sel;
            end
            if (w_in_acc && w_res_valid) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // slot payload and result register
    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_slot_id[w_free_idx]      <= r_next_id;
            r_slot_owner[w_free_idx]   <= w_tag;
            r_slot_address[w_free_idx] <= w_addr;
            r_slot_size[w_free_idx]    <= w_size;
            r_slot_write[w_free_idx]   <= w_req_wr;
            r_slot_issue[w_free_idx]   <= r_cycle;
        end
        if (w_in_acc && w_res_valid) begin
            r_o_user <= w_outc;
            r_o_res  <= w_res;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tdata  = cbtt_pkg::OUT_DATA_W'(r_o_res);

endmodule
